### rtl/cplb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_pkg
// Shared types, codes and constants of the protection check core.
// ----------------------------------------------------------------------------
package cplb_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int MASK_W      = 16;
  localparam int CELL_IDX_W  = 5;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_START = 2'd1,
    ACT_FLAGS = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    OUT_OK    = 3'd0,
    OUT_MISS  = 3'd1,
    OUT_PROT  = 3'd2,
    OUT_MULTI = 3'd3,
    OUT_ALIGN = 3'd4,
    OUT_HWERR = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_SKIP = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    REG_DATA_EN = 2'd0,
    REG_INST_EN = 2'd1,
    REG_SYS_BASE = 2'd2,
    REG_UNUSED  = 2'd3
  } cfg_reg_t;

  localparam int F_VALID   = 0;
  localparam int F_USER_RD = 2;
  localparam int F_USER_WR = 3;
  localparam int F_SUPV_WR = 4;
  localparam int F_DIRTY   = 7;
  localparam int F_CHBL    = 12;
  localparam int F_WT      = 14;
  localparam int F_PAGE_LO = 16;

  localparam logic [31:0] SYS_BASE_RST = 32'hFFC0_0000;
  localparam logic [7:0]  L1_TOP_BYTE  = 8'hFF;
  localparam logic [11:0] L1_INST_MB   = 12'hFFA;

  typedef struct packed {
    logic       act;
    logic [1:0] hits;
    logic       excp;
  } tok_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        wr;
    logic        supv;
    logic        inst;
  } ctx_t;

  typedef struct packed {
    logic start_we;
    logic flags_we;
    logic inst;
  } ent_wr_t;

  function automatic logic [32:0] page_bytes(input logic [1:0] code);
    logic [32:0] r;
    unique case (code)
      2'd0:    r = 33'h0_0000_0400;
      2'd1:    r = 33'h0_0000_1000;
      2'd2:    r = 33'h0_0010_0000;
      default: r = 33'h0_0040_0000;
    endcase
    return r;
  endfunction

endpackage

### rtl/cplb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_if
// Handshake channels of the protection check core.
// ----------------------------------------------------------------------------
interface cplb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        side_inst;
  logic [3:0]  entry_index;
  logic [31:0] write_value;
  logic [31:0] address;
  logic        is_write;
  logic [2:0]  size_log2;
  logic        supervisor;
  logic        second_dag;
  logic [31:0] program_counter;
  modport source (output valid, action, side_inst, entry_index, write_value, address,
                  is_write, size_log2, supervisor, second_dag, program_counter,
                  input ready);
  modport sink (input valid, action, side_inst, entry_index, write_value, address,
                is_write, size_log2, supervisor, second_dag, program_counter,
                output ready);
endinterface

interface cplb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [15:0] hit_mask;
  logic [19:0] data_fault_status;
  logic [31:0] data_fault_address;
  logic [19:0] inst_fault_status;
  logic [31:0] inst_fault_address;
  modport source (output valid, outcome, hit_mask, data_fault_status, data_fault_address,
                  inst_fault_status, inst_fault_address, input ready);
  modport sink (input valid, outcome, hit_mask, data_fault_status, data_fault_address,
                inst_fault_status, inst_fault_address, output ready);
endinterface

interface cplb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/cplb_protection_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_protection_check_core
// Memory protection check over a row of entry cells with implicit region rules.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat carries
//  in_ch     sink       action, entry write or access to check
//  out_ch    source     outcome, hit mask and fault registers
//  cfg_ch    sink       table enables and system register base
//
//  A check with its table enabled sends a token down the cell row, one cell a
//  cycle; the result loads when it leaves the last cell. Any other beat passes
//  through the skip state. One beat is in flight at a time; in_ch.ready is low
//  from acceptance until the result beat leaves. Reset clears all entries.
module cplb_protection_check_core #(
  parameter int ENTRIES = cplb_pkg::ENTRIES_DEF
) (
  input logic clk,
  input logic rst_n,
  cplb_in_if.sink    in_ch,
  cplb_out_if.source out_ch,
  cplb_cfg_if.sink   cfg_ch
);

  cplb_pkg::state_t state_r, state_nxt;
  cplb_pkg::ctx_t   ctx_r;
  cplb_pkg::tok_t   tok [ENTRIES+1];
  logic [ENTRIES-1:0] hits;
  logic        data_en_r, inst_en_r;
  logic [31:0] sys_base_r;
  logic        check_r, dag_r, launch_r;
  logic [2:0]  szlog_r;
  logic [31:0] pc_r;
  logic        in_acc, load;
  cplb_pkg::tok_t fin;
  logic [cplb_pkg::MASK_W-1:0] mask;
  logic [6:0]  amask;
  logic        sysreg, l1, mb_a;
  cplb_pkg::outcome_t oc;
  logic        log_en;
  logic [19:0] status;
  cplb_pkg::outcome_t outcome_r;
  logic [cplb_pkg::MASK_W-1:0] mask_r;
  logic [19:0] dfs_r, ifs_r;
  logic [31:0] dfa_r, ifa_r;
  logic        en_sel;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_en_r  <= 1'b0;
      inst_en_r  <= 1'b0;
      sys_base_r <= cplb_pkg::SYS_BASE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cplb_pkg::cfg_reg_t'(cfg_ch.index))
        cplb_pkg::REG_DATA_EN:  data_en_r  <= cfg_ch.data[0];
        cplb_pkg::REG_INST_EN:  inst_en_r  <= cfg_ch.data[0];
        cplb_pkg::REG_SYS_BASE: sys_base_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_acc = in_ch.valid && in_ch.ready;
  assign en_sel = in_ch.side_inst ? inst_en_r : data_en_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cplb_pkg::ST_IDLE:
        if (in_acc) begin
          state_nxt = (in_ch.action == cplb_pkg::ACT_CHECK && en_sel) ?
                      cplb_pkg::ST_WALK : cplb_pkg::ST_SKIP;
        end
      cplb_pkg::ST_WALK: if (tok[ENTRIES].act) state_nxt = cplb_pkg::ST_OUT;
      cplb_pkg::ST_SKIP: state_nxt = cplb_pkg::ST_OUT;
      default:           if (out_ch.ready) state_nxt = cplb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state_r == cplb_pkg::ST_IDLE);
    out_ch.valid = (state_r == cplb_pkg::ST_OUT);
    load = (state_r == cplb_pkg::ST_SKIP) ||
           (state_r == cplb_pkg::ST_WALK && tok[ENTRIES].act);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cplb_pkg::ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc && in_ch.action == cplb_pkg::ACT_CHECK && en_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ctx_r.addr <= in_ch.address;
      ctx_r.wr   <= in_ch.is_write;
      ctx_r.supv <= in_ch.supervisor;
      ctx_r.inst <= in_ch.side_inst;
      check_r    <= (in_ch.action == cplb_pkg::ACT_CHECK);
      dag_r      <= in_ch.second_dag;
      szlog_r    <= in_ch.size_log2;
      pc_r       <= in_ch.program_counter;
    end
  end

  assign tok[0] = '{act: launch_r, hits: 2'd0, excp: 1'b0};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cplb_pkg::ent_wr_t wr;
    assign wr.inst     = in_ch.side_inst;
    assign wr.start_we = in_acc && in_ch.action == cplb_pkg::ACT_START &&
                         {1'b0, in_ch.entry_index} == cplb_pkg::CELL_IDX_W'(i);
    assign wr.flags_we = in_acc && in_ch.action == cplb_pkg::ACT_FLAGS &&
                         {1'b0, in_ch.entry_index} == cplb_pkg::CELL_IDX_W'(i);
    cplb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_i   (wr),
      .wval_i (in_ch.write_value),
      .ctx_i  (ctx_r),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .hit_o  (hits[i])
    );
  end

  for (genvar i = 0; i < cplb_pkg::MASK_W; i++) begin : g_mask
    if (i < ENTRIES) begin : g_on
      assign mask[i] = (state_r == cplb_pkg::ST_WALK) ? hits[i] : 1'b0;
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  always_comb begin
    fin    = (state_r == cplb_pkg::ST_WALK) ? tok[ENTRIES] :
             cplb_pkg::tok_t'{act: 1'b1, hits: 2'd1, excp: 1'b0};
    amask  = 7'(8'd1 << szlog_r) - 7'd1;
    sysreg = ctx_r.addr >= sys_base_r;
    l1     = ctx_r.addr[31:24] == cplb_pkg::L1_TOP_BYTE;
    mb_a   = ctx_r.addr[31:20] == cplb_pkg::L1_INST_MB;
    if (!check_r) begin
      oc = cplb_pkg::OUT_OK;
    end else if (fin.excp || fin.hits == 2'd2) begin
      oc = (fin.hits == 2'd2) ? cplb_pkg::OUT_MULTI : cplb_pkg::OUT_PROT;
    end else if (|(ctx_r.addr[6:0] & amask)) begin
      oc = cplb_pkg::OUT_ALIGN;
    end else if (sysreg) begin
      if (ctx_r.inst) oc = cplb_pkg::OUT_MISS;
      else oc = (!ctx_r.supv || dag_r) ? cplb_pkg::OUT_PROT : cplb_pkg::OUT_OK;
    end else if (l1) begin
      if (ctx_r.inst) oc = mb_a ? cplb_pkg::OUT_OK : cplb_pkg::OUT_PROT;
      else oc = mb_a ? cplb_pkg::OUT_HWERR : cplb_pkg::OUT_OK;
    end else begin
      oc = (fin.hits == 2'd1) ? cplb_pkg::OUT_OK : cplb_pkg::OUT_MISS;
    end
    log_en = (oc != cplb_pkg::OUT_OK) && (oc != cplb_pkg::OUT_HWERR);
    status = {oc == cplb_pkg::OUT_MISS, dag_r, ctx_r.supv, ctx_r.wr, mask};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      outcome_r <= oc;
      mask_r    <= check_r ? mask : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfs_r <= '0;
      dfa_r <= '0;
      ifs_r <= '0;
      ifa_r <= '0;
    end else if (load && log_en) begin
      if (ctx_r.inst) begin
        ifa_r <= ctx_r.addr;
        ifs_r <= status;
      end else begin
        ifa_r <= pc_r;
        ifs_r <= {2'b00, ctx_r.supv, 17'd0};
        dfa_r <= ctx_r.addr;
        dfs_r <= status;
      end
    end
  end

  assign out_ch.outcome            = outcome_r;
  assign out_ch.hit_mask           = mask_r;
  assign out_ch.data_fault_status  = dfs_r;
  assign out_ch.data_fault_address = dfa_r;
  assign out_ch.inst_fault_status  = ifs_r;
  assign out_ch.inst_fault_address = ifa_r;

endmodule

### rtl/cplb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_cell
// One protection entry of each table, checked as the walk token passes by.
// ----------------------------------------------------------------------------
module cplb_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  cplb_pkg::ent_wr_t wr_i,
  input  logic [31:0]      wval_i,
  input  cplb_pkg::ctx_t   ctx_i,
  input  cplb_pkg::tok_t   tok_i,
  output cplb_pkg::tok_t   tok_o,
  output logic             hit_o
);

  logic [31:0] d_start_r, d_flags_r, i_start_r, i_flags_r;
  logic [31:0] st, fl;
  logic [32:0] hi;
  logic        hit, excp;
  cplb_pkg::tok_t tok_r, tok_nxt;
  logic        hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_start_r <= '0;
      d_flags_r <= '0;
      i_start_r <= '0;
      i_flags_r <= '0;
    end else begin
      if (wr_i.start_we && !wr_i.inst) d_start_r <= wval_i;
      if (wr_i.flags_we && !wr_i.inst) d_flags_r <= wval_i;
      if (wr_i.start_we && wr_i.inst)  i_start_r <= wval_i;
      if (wr_i.flags_we && wr_i.inst)  i_flags_r <= wval_i;
    end
  end

  always_comb begin
    st   = ctx_i.inst ? i_start_r : d_start_r;
    fl   = ctx_i.inst ? i_flags_r : d_flags_r;
    hi   = {1'b0, st} + cplb_pkg::page_bytes(fl[cplb_pkg::F_PAGE_LO +: 2]);
    hit  = tok_i.act && fl[cplb_pkg::F_VALID] && (ctx_i.addr >= st)
           && ({1'b0, ctx_i.addr} < hi);
    excp = 1'b0;
    if (ctx_i.wr) begin
      if (!ctx_i.supv && !fl[cplb_pkg::F_USER_WR]) excp = 1'b1;
      if (ctx_i.supv && !fl[cplb_pkg::F_SUPV_WR])  excp = 1'b1;
      if (fl[cplb_pkg::F_CHBL] && !fl[cplb_pkg::F_WT] && !fl[cplb_pkg::F_DIRTY])
        excp = 1'b1;
    end else if (!ctx_i.supv && !fl[cplb_pkg::F_USER_RD]) begin
      excp = 1'b1;
    end
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.hits = (tok_i.hits == 2'd2) ? 2'd2 : tok_i.hits + 2'd1;
      tok_nxt.excp = tok_i.excp | excp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i.act) hit_r <= hit;
  end

  assign tok_o = tok_r;
  assign hit_o = hit_r;

endmodule

### rtl/cplb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_checker
// Port-level checks of the protection check core.
// ----------------------------------------------------------------------------
module cplb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_outcome,
  input logic [15:0] out_hit_mask
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result waits");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action != cplb_pkg::ACT_CHECK) |-> ##2
    (out_valid && out_outcome == cplb_pkg::OUT_OK && out_hit_mask == 16'd0))
    else $error("entry write beat gave a wrong result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_outcome)))
    else $error("stalled result changed");

endmodule

bind cplb_protection_check_core cplb_checker u_cplb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_outcome  (out_ch.outcome),
  .out_hit_mask (out_ch.hit_mask)
);

### tb/sv/cplb_protection_check_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_protection_check_core_test
// Self-checking bench for the protection check core. A queue of pending beats
// feeds a clocked driver, a clocked monitor compares each result beat with a
// behavioural prediction of the entry tables, region rules and fault logging.
// ----------------------------------------------------------------------------
module cplb_protection_check_core_test;

  typedef struct {
    cplb_pkg::act_t action;
    logic        side_inst;
    logic [3:0]  entry_index;
    logic [31:0] write_value;
    logic [31:0] address;
    logic        is_write;
    logic [2:0]  size_log2;
    logic        supervisor;
    logic        second_dag;
    logic [31:0] program_counter;
  } access_t;

  typedef struct {
    cplb_pkg::outcome_t outcome;
    logic [15:0] hit_mask;
    logic [19:0] dstat;
    logic [31:0] daddr;
    logic [19:0] istat;
    logic [31:0] iaddr;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  cplb_in_if  in_ch ();
  cplb_out_if out_ch ();
  cplb_cfg_if cfg_ch ();

  cplb_protection_check_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  access_t     pending_beats[$];
  verdict_t    expected_verdicts[$];
  int          errors = 0;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 35;
  logic        hold_sender = 1'b0;

  logic        m_data_en, m_inst_en;
  logic [31:0] m_sys_base;
  logic [31:0] m_start[2][16];
  logic [31:0] m_flags[2][16];
  logic [19:0] m_dstat, m_istat;
  logic [31:0] m_daddr, m_iaddr;

  function automatic verdict_t predict_verdict(access_t a);
    verdict_t v;
    int       hits;
    logic     excp;
    logic [15:0] mask;
    logic [31:0] f;
    logic [32:0] lo, hi;
    logic [31:0] sz;
    cplb_pkg::outcome_t oc;
    logic     log_it;
    logic [19:0] status;
    int s;
    s = int'(a.side_inst);
    hits = 0; excp = 1'b0; mask = '0; oc = cplb_pkg::OUT_OK; log_it = 1'b0;
    if (a.action == cplb_pkg::ACT_START) begin
      m_start[s][a.entry_index] = a.write_value;
    end else if (a.action == cplb_pkg::ACT_FLAGS) begin
      m_flags[s][a.entry_index] = a.write_value;
    end else if (a.action == cplb_pkg::ACT_CHECK) begin
      if (!(a.side_inst ? m_inst_en : m_data_en)) begin
        hits = 1;
      end else begin
        for (int i = 0; i < 16; i++) begin
          f = m_flags[s][i];
          lo = {1'b0, m_start[s][i]};
          hi = lo + cplb_pkg::page_bytes(f[17:16]);
          if (f[cplb_pkg::F_VALID] && {1'b0, a.address} >= lo && {1'b0, a.address} < hi) begin
            hits++;
            mask[i] = 1'b1;
            if (a.is_write) begin
              if (!a.supervisor && !f[cplb_pkg::F_USER_WR]) excp = 1'b1;
              if (a.supervisor && !f[cplb_pkg::F_SUPV_WR]) excp = 1'b1;
              if (!f[cplb_pkg::F_WT] && f[cplb_pkg::F_CHBL] && !f[cplb_pkg::F_DIRTY])
                excp = 1'b1;
            end else if (!a.supervisor && !f[cplb_pkg::F_USER_RD]) begin
              excp = 1'b1;
            end
          end
        end
      end
      if (excp || hits >= 2) begin
        oc = (hits >= 2) ? cplb_pkg::OUT_MULTI : cplb_pkg::OUT_PROT;
      end else begin
        sz = 32'd1 << a.size_log2;
        if ((a.address & (sz - 32'd1)) != 32'd0) begin
          oc = cplb_pkg::OUT_ALIGN;
        end else if (a.address >= m_sys_base) begin
          if (a.side_inst) oc = cplb_pkg::OUT_MISS;
          else oc = (!a.supervisor || a.second_dag) ? cplb_pkg::OUT_PROT : cplb_pkg::OUT_OK;
        end else if (a.address[31:24] == cplb_pkg::L1_TOP_BYTE) begin
          if (a.side_inst)
            oc = (a.address[31:20] == cplb_pkg::L1_INST_MB) ? cplb_pkg::OUT_OK :
                                                               cplb_pkg::OUT_PROT;
          else
            oc = (a.address[31:20] == cplb_pkg::L1_INST_MB) ? cplb_pkg::OUT_HWERR :
                                                               cplb_pkg::OUT_OK;
        end else begin
          oc = (hits == 1) ? cplb_pkg::OUT_OK : cplb_pkg::OUT_MISS;
        end
      end
      log_it = (oc != cplb_pkg::OUT_OK && oc != cplb_pkg::OUT_HWERR);
      if (log_it) begin
        status = {oc == cplb_pkg::OUT_MISS, a.second_dag, a.supervisor, a.is_write, mask};
        if (a.side_inst) begin
          m_iaddr = a.address; m_istat = status;
        end else begin
          m_iaddr = a.program_counter; m_istat = {2'b0, a.supervisor, 17'b0};
          m_daddr = a.address; m_dstat = status;
        end
      end
    end
    v.outcome = oc; v.hit_mask = mask;
    v.dstat = m_dstat; v.daddr = m_daddr; v.istat = m_istat; v.iaddr = m_iaddr;
    return v;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_verdicts.push_back(predict_verdict(pending_beats.pop_front()));
      if (pending_beats.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid           <= 1'b1;
        in_ch.action          <= pending_beats[0].action;
        in_ch.side_inst       <= pending_beats[0].side_inst;
        in_ch.entry_index     <= pending_beats[0].entry_index;
        in_ch.write_value     <= pending_beats[0].write_value;
        in_ch.address         <= pending_beats[0].address;
        in_ch.is_write        <= pending_beats[0].is_write;
        in_ch.size_log2       <= pending_beats[0].size_log2;
        in_ch.supervisor      <= pending_beats[0].supervisor;
        in_ch.second_dag      <= pending_beats[0].second_dag;
        in_ch.program_counter <= pending_beats[0].program_counter;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result beat, outcome %0d", $time, out_ch.outcome);
          errors++;
        end else begin
          e = expected_verdicts.pop_front();
          if (out_ch.outcome !== e.outcome || out_ch.hit_mask !== e.hit_mask ||
              out_ch.data_fault_status !== e.dstat ||
              out_ch.data_fault_address !== e.daddr ||
              out_ch.inst_fault_status !== e.istat ||
              out_ch.inst_fault_address !== e.iaddr) begin
            $display("%0t: mismatch expected %0d %h %h %h %h %h actual %0d %h %h %h %h %h",
                     $time, e.outcome, e.hit_mask, e.dstat, e.daddr, e.istat, e.iaddr,
                     out_ch.outcome, out_ch.hit_mask, out_ch.data_fault_status,
                     out_ch.data_fault_address, out_ch.inst_fault_status,
                     out_ch.inst_fault_address);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = cplb_pkg::REG_DATA_EN;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = cplb_pkg::ACT_NONE;
    in_ch.side_inst = 1'b0;
    in_ch.entry_index = '0;
    in_ch.write_value = '0;
    in_ch.address = '0;
    in_ch.is_write = 1'b0;
    in_ch.size_log2 = '0;
    in_ch.supervisor = 1'b0;
    in_ch.second_dag = 1'b0;
    in_ch.program_counter = '0;
    out_ch.ready = 1'b0;
  end

  task automatic write_register(cplb_pkg::cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      cplb_pkg::REG_DATA_EN:  m_data_en = value[0];
      cplb_pkg::REG_INST_EN:  m_inst_en = value[0];
      cplb_pkg::REG_SYS_BASE: m_sys_base = value;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (pending_beats.size() > 0 || in_ch.valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic access_t idle_beat();
    access_t a;
    a.action = cplb_pkg::ACT_CHECK; a.side_inst = 1'($urandom_range(1));
    a.entry_index = 4'($urandom);
    a.write_value = $urandom; a.address = $urandom; a.is_write = 1'($urandom_range(1));
    a.size_log2 = 3'($urandom_range(7)); a.supervisor = 1'($urandom_range(1));
    a.second_dag = 1'($urandom_range(1)); a.program_counter = $urandom;
    return a;
  endfunction

  task automatic queue_table_fill(logic side, bit overlaps);
    access_t a;
    logic [31:0] base;
    for (int i = 0; i < 16; i++) begin
      a = idle_beat();
      a.side_inst = side; a.entry_index = 4'(i);
      base = 32'h1000_0000 + (overlaps ? 32'h400 * ($urandom_range(3)) : 32'h40_0000 * i);
      if ($urandom_range(9) == 0) base = 32'hFFFF_FC00;
      a.action = cplb_pkg::ACT_START; a.write_value = base;
      pending_beats.push_back(a);
      a.action = cplb_pkg::ACT_FLAGS;
      a.write_value = {14'($urandom), 2'($urandom), 16'($urandom)};
      if ($urandom_range(3) != 0) a.write_value[cplb_pkg::F_VALID] = 1'b1;
      pending_beats.push_back(a);
    end
  endtask

  task automatic queue_random_checks(int n, logic side);
    access_t a;
    for (int i = 0; i < n; i++) begin
      a = idle_beat();
      a.side_inst = side;
      case ($urandom_range(9))
        0: a.action = cplb_pkg::act_t'($urandom_range(3));
        1, 2: a.address = {8'hFF, 24'($urandom)};
        3: a.address = 32'hFFFF_FC00 + $urandom_range(1023);
        default: a.address = 32'h1000_0000 + ($urandom_range(16 * 4096) << 6) +
                             $urandom_range(3) * 32'h0100_0000 * $urandom_range(1);
      endcase
      if ($urandom_range(3) != 0) a.size_log2 = 3'($urandom_range(2));
      pending_beats.push_back(a);
    end
  endtask

  initial begin
    access_t a;
    m_data_en = 1'b0; m_inst_en = 1'b0; m_sys_base = cplb_pkg::SYS_BASE_RST;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < 16; i++) begin
        m_start[s][i] = '0; m_flags[s][i] = '0;
      end
    m_dstat = '0; m_istat = '0; m_daddr = '0; m_iaddr = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats with tables disabled: region rules and field extremes.
    for (int k = 0; k < 18; k++) begin
      a = idle_beat();
      a.side_inst = k[0]; a.supervisor = k[1]; a.second_dag = k[2];
      a.is_write = k[0] ^ k[1];
      a.size_log2 = (k < 8) ? 3'd0 : 3'(k - 8);
      case (k % 6)
        0: a.address = 32'hFFC0_0000;
        1: a.address = 32'hFFA0_0000;
        2: a.address = 32'hFF80_0000;
        3: a.address = 32'h0000_0000;
        4: a.address = 32'hFFFF_FFFF;
        default: a.address = 32'h0000_0082;
      endcase
      if (k == 16) a.action = cplb_pkg::ACT_NONE;
      if (k == 17) begin
        a.action = cplb_pkg::ACT_START; a.entry_index = 4'hF; a.write_value = 32'hFFFF_FFFF;
      end
      pending_beats.push_back(a);
    end
    drain_results();

    write_register(cplb_pkg::REG_DATA_EN, 32'h1);
    write_register(cplb_pkg::REG_INST_EN, 32'h1);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int r = 0; r < 6; r++) begin
      queue_table_fill(r[0], r[1]);
      queue_random_checks(150, r[0]);
      if (r == 2) begin
        drain_results();
        hold_sender = 1'b1;
        drain_results();
        hold_sender = 1'b0;
      end
      drain_results();
      send_idle_pct = 35; recv_idle_pct = 35;
      case (r)
        0: write_register(cplb_pkg::REG_SYS_BASE, 32'h0000_0000);
        1: write_register(cplb_pkg::REG_SYS_BASE, 32'hFFFF_FFFF);
        2: write_register(cplb_pkg::REG_DATA_EN, 32'h0);
        3: write_register(cplb_pkg::REG_INST_EN, 32'h0);
        4: begin
          write_register(cplb_pkg::REG_DATA_EN, 32'h1);
          write_register(cplb_pkg::REG_SYS_BASE, 32'hFF90_0000);
        end
        default: write_register(cplb_pkg::REG_SYS_BASE, cplb_pkg::SYS_BASE_RST);
      endcase
    end
    queue_random_checks(200, 1'b0);
    drain_results();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
